// File: design/proximity_warning_controller_top_assert.svh
// Assertion macros shared by the proximity warning controller RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// Depends on nothing; included by name from the module file.
`ifndef PROXIMITY_WARNING_CONTROLLER_TOP_ASSERT_SVH
`define PROXIMITY_WARNING_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pwc_pkg.sv
// Package for the proximity warning controller: beat types, widths and codes.
// Used by proximity_warning_controller_top; depends on nothing.
`timescale 1ns / 1ps

package pwc_pkg;

  // Field widths.
  localparam int ECHO_BITS = 16;
  localparam int IR_W      = 10;
  localparam int ZONE_W    = 10;
  localparam int HOLD_W    = 14;
  localparam int DIST_W    = 19;
  localparam int ANGLE_W   = 8;
  localparam int MSG_W     = 2;
  localparam int LED_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;

  // Echo time to Q11.8 centimeters: echo * 281 >> 6.
  localparam int ECHO_SCALE   = 281;
  localparam int ECHO_SCALE_W = 9;
  localparam int ECHO_SHIFT   = 6;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Item kinds.
  localparam logic KIND_MEAS = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Message codes.
  localparam logic [MSG_W-1:0] MSG_SAFE    = 2'd0;
  localparam logic [MSG_W-1:0] MSG_FAR     = 2'd1;
  localparam logic [MSG_W-1:0] MSG_WARNING = 2'd2;
  localparam logic [MSG_W-1:0] MSG_DANGER  = 2'd3;

  // LED patterns: bit 0 green, bit 1 blue, bit 2 red.
  localparam logic [LED_W-1:0] LED_OFF        = 3'b000;
  localparam logic [LED_W-1:0] LED_GREEN      = 3'b001;
  localparam logic [LED_W-1:0] LED_GREEN_BLUE = 3'b011;
  localparam logic [LED_W-1:0] LED_RED        = 3'b100;
  localparam logic [LED_W-1:0] LED_ALL        = 3'b111;

  // Servo angles in degrees.
  localparam logic [ANGLE_W-1:0] ANGLE_REST = 8'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_WARN = 8'd100;
  localparam logic [ANGLE_W-1:0] ANGLE_CRIT = 8'd180;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IR_THRESHOLD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING_CM         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DANGER_CM          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_CM        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_HOLD_WARN_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_HOLD_CRIT_MS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZER_HOLD_MS     = 3'd6;

  // Configuration reset values.
  localparam logic [IR_W-1:0]   RST_IR_THRESHOLD       = 10'd500;
  localparam logic [ZONE_W-1:0] RST_WARNING_CM         = 10'd50;
  localparam logic [ZONE_W-1:0] RST_DANGER_CM          = 10'd35;
  localparam logic [ZONE_W-1:0] RST_CRITICAL_CM        = 10'd20;
  localparam logic [HOLD_W-1:0] RST_SERVO_HOLD_WARN_MS = 14'd7000;
  localparam logic [HOLD_W-1:0] RST_SERVO_HOLD_CRIT_MS = 14'd10000;
  localparam logic [HOLD_W-1:0] RST_BUZZER_HOLD_MS     = 14'd7000;

  typedef struct packed {
    logic                 kind;
    logic [IR_W-1:0]      ir_level;
    logic [ECHO_BITS-1:0] echo_us;
  } pwc_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance_q8;
    logic               led_green;
    logic               led_blue;
    logic               led_red;
    logic [ANGLE_W-1:0] servo_angle;
    logic               buzzer_on;
    logic               short_alarm;
    logic               vibrate;
    logic [MSG_W-1:0]   message;
  } pwc_out_t;

endpackage

// File: design/proximity_warning_controller_top.sv
// Proximity warning controller, top level and only module.
// Depends on pwc_pkg and on proximity_warning_controller_top_assert.svh.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake               Beat
//  in_       input      in_valid / in_ready     pwc_in_t: kind, ir_level, echo_us
//  out_      output     out_valid / out_ready   pwc_out_t: distance and indicators
//  cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
//  An input beat lands in the input register and is evaluated from there;
//  out_valid rises when the result register takes the evaluated beat.
//  With out_ready held high one beat is accepted every cycle.
//  A stalled result keeps the evaluation stage full, so in_ready drops and the
//  stall backs up to the sender. Synchronous active-low reset restores the
//  register defaults and clears all holds; there is no clearing pass.

`include "proximity_warning_controller_top_assert.svh"

module proximity_warning_controller_top
  import pwc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel: measurements and millisecond ticks.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pwc_in_t              in_data,
  // Result channel: one beat per input beat.
  output logic                 out_valid,
  input  logic                 out_ready,
  output pwc_out_t             out_data,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  // Distance arithmetic widths follow the echo width.
  localparam int PROD_W = ECHO_BITS + ECHO_SCALE_W;
  localparam int SHR_W  = PROD_W - ECHO_SHIFT;
  localparam int WIDE_W = (SHR_W > DIST_W) ? SHR_W : DIST_W;

  // Configuration registers.
  logic [IR_W-1:0]   ir_threshold_r;
  logic [ZONE_W-1:0] warning_cm_r;
  logic [ZONE_W-1:0] danger_cm_r;
  logic [ZONE_W-1:0] critical_cm_r;
  logic [HOLD_W-1:0] servo_hold_warn_r;
  logic [HOLD_W-1:0] servo_hold_crit_r;
  logic [HOLD_W-1:0] buzzer_hold_r;

  // Pipeline registers.
  logic     in_valid_r;
  pwc_in_t  in_r;
  logic     out_valid_r;
  pwc_out_t out_r;

  // Controller state and its next values.
  logic               chirp_done_r, chirp_done_nxt;
  logic               servo_busy_r, servo_busy_nxt;
  logic [HOLD_W-1:0]  servo_left_r, servo_left_nxt;
  logic [ANGLE_W-1:0] servo_pos_r, servo_pos_nxt;
  logic               buzz_busy_r, buzz_busy_nxt;
  logic [HOLD_W-1:0]  buzz_left_r, buzz_left_nxt;
  logic [LED_W-1:0]   led_pattern_r, led_pattern_nxt;
  logic [MSG_W-1:0]   message_r, message_nxt;
  pwc_out_t           out_nxt;

  // Datapath signals.
  logic [PROD_W-1:0] echo_prod;
  logic [WIDE_W-1:0] dist_wide;
  logic [DIST_W-1:0] dist_sat;
  logic              obstacle;
  logic              advance;
  logic              chirp;
  logic              vib;

  // The evaluation stage moves when it holds a beat and the result register
  // is free or being emptied in this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // One constant multiply, then saturation to the 19-bit distance field.
  assign echo_prod = PROD_W'(in_r.echo_us) * PROD_W'(ECHO_SCALE);
  assign dist_wide = WIDE_W'(echo_prod[PROD_W-1:ECHO_SHIFT]);
  assign dist_sat  = (dist_wide > WIDE_W'(DIST_MAX)) ? DIST_MAX : dist_wide[DIST_W-1:0];
  assign obstacle  = in_r.ir_level < ir_threshold_r;

  always_comb begin
    chirp_done_nxt  = chirp_done_r;
    servo_busy_nxt  = servo_busy_r;
    servo_left_nxt  = servo_left_r;
    servo_pos_nxt   = servo_pos_r;
    buzz_busy_nxt   = buzz_busy_r;
    buzz_left_nxt   = buzz_left_r;
    led_pattern_nxt = led_pattern_r;
    message_nxt     = message_r;
    chirp           = 1'b0;
    vib             = 1'b0;

    if (in_r.kind == KIND_TICK) begin
      // A hold of H ms is released on the tick after the count reaches zero.
      if (servo_busy_r) begin
        if (servo_left_r == '0) begin
          servo_busy_nxt = 1'b0;
          servo_pos_nxt  = ANGLE_REST;
        end else begin
          servo_left_nxt = servo_left_r - HOLD_W'(1);
        end
      end
      if (buzz_busy_r) begin
        if (buzz_left_r == '0) begin
          buzz_busy_nxt = 1'b0;
        end else begin
          buzz_left_nxt = buzz_left_r - HOLD_W'(1);
        end
      end
    end else if (obstacle) begin
      priority if (dist_sat > DIST_W'({warning_cm_r, 8'h00})) begin
        // Far zone: chirp once per approach.
        led_pattern_nxt = LED_GREEN;
        message_nxt     = MSG_FAR;
        if (!chirp_done_r) begin
          chirp          = 1'b1;
          chirp_done_nxt = 1'b1;
        end
      end else if (dist_sat > DIST_W'({danger_cm_r, 8'h00})) begin
        led_pattern_nxt = LED_GREEN_BLUE;
        message_nxt     = MSG_WARNING;
        servo_pos_nxt   = ANGLE_WARN;
        servo_busy_nxt  = 1'b1;
        servo_left_nxt  = servo_hold_warn_r;
        vib             = 1'b1;
        chirp           = !buzz_busy_r;
      end else begin
        led_pattern_nxt = (dist_sat > DIST_W'({critical_cm_r, 8'h00})) ? LED_RED : LED_ALL;
        message_nxt     = MSG_DANGER;
        servo_pos_nxt   = ANGLE_CRIT;
        servo_busy_nxt  = 1'b1;
        servo_left_nxt  = servo_hold_crit_r;
        buzz_busy_nxt   = 1'b1;
        buzz_left_nxt   = buzzer_hold_r;
      end
    end else begin
      // Path clear: rearm the far-zone chirp.
      led_pattern_nxt = LED_GREEN;
      message_nxt     = MSG_SAFE;
      chirp_done_nxt  = 1'b0;
    end

    out_nxt.distance_q8 = ((in_r.kind == KIND_MEAS) && obstacle) ? dist_sat : '0;
    out_nxt.led_green   = led_pattern_nxt[0];
    out_nxt.led_blue    = led_pattern_nxt[1];
    out_nxt.led_red     = led_pattern_nxt[2];
    out_nxt.servo_angle = servo_pos_nxt;
    out_nxt.buzzer_on   = buzz_busy_nxt;
    out_nxt.short_alarm = chirp;
    out_nxt.vibrate     = vib;
    out_nxt.message     = message_nxt;
  end

  // Control state, configuration and holds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_threshold_r    <= RST_IR_THRESHOLD;
      warning_cm_r      <= RST_WARNING_CM;
      danger_cm_r       <= RST_DANGER_CM;
      critical_cm_r     <= RST_CRITICAL_CM;
      servo_hold_warn_r <= RST_SERVO_HOLD_WARN_MS;
      servo_hold_crit_r <= RST_SERVO_HOLD_CRIT_MS;
      buzzer_hold_r     <= RST_BUZZER_HOLD_MS;
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      chirp_done_r      <= 1'b0;
      servo_busy_r      <= 1'b0;
      servo_left_r      <= '0;
      servo_pos_r       <= ANGLE_REST;
      buzz_busy_r       <= 1'b0;
      buzz_left_r       <= '0;
      led_pattern_r     <= LED_OFF;
      message_r         <= MSG_SAFE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_IR_THRESHOLD:       ir_threshold_r    <= cfg_wdata[IR_W-1:0];
          CFG_WARNING_CM:         warning_cm_r      <= cfg_wdata[ZONE_W-1:0];
          CFG_DANGER_CM:          danger_cm_r       <= cfg_wdata[ZONE_W-1:0];
          CFG_CRITICAL_CM:        critical_cm_r     <= cfg_wdata[ZONE_W-1:0];
          CFG_SERVO_HOLD_WARN_MS: servo_hold_warn_r <= cfg_wdata[HOLD_W-1:0];
          CFG_SERVO_HOLD_CRIT_MS: servo_hold_crit_r <= cfg_wdata[HOLD_W-1:0];
          CFG_BUZZER_HOLD_MS:     buzzer_hold_r     <= cfg_wdata[HOLD_W-1:0];
          default: ;
        endcase
      end

      if (in_ready) begin
        in_valid_r <= in_valid;
      end

      if (advance) begin
        out_valid_r   <= 1'b1;
        chirp_done_r  <= chirp_done_nxt;
        servo_busy_r  <= servo_busy_nxt;
        servo_left_r  <= servo_left_nxt;
        servo_pos_r   <= servo_pos_nxt;
        buzz_busy_r   <= buzz_busy_nxt;
        buzz_left_r   <= buzz_left_nxt;
        led_pattern_r <= led_pattern_nxt;
        message_r     <= message_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  `PWC_ASSERT_NOW(a_servo_rest_when_idle, clk, rst_n,
                  !servo_busy_r, servo_pos_r == ANGLE_REST,
                  "servo off its rest angle while not holding")
  `PWC_ASSERT_NOW(a_servo_angle_legal, clk, rst_n, 1'b1,
                  (servo_pos_r == ANGLE_REST) || (servo_pos_r == ANGLE_WARN) ||
                  (servo_pos_r == ANGLE_CRIT),
                  "servo angle outside the zone set")
  `PWC_ASSERT_NOW(a_vibrate_warning_only, clk, rst_n,
                  out_valid_r && out_r.vibrate, out_r.message == MSG_WARNING,
                  "vibration pulse outside the warning zone")
  `PWC_ASSERT_NOW(a_warn_chirp_no_buzzer, clk, rst_n,
                  out_valid_r && out_r.short_alarm && (out_r.message == MSG_WARNING),
                  !out_r.buzzer_on, "warning chirp while buzzer held")
  `PWC_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, out_valid_r,
                   "evaluated beat did not reach the result register")

endmodule
